@@ src/fbpa_pkg.sv @@
`timescale 1ns / 1ps

package fbpa_pkg;

  localparam int SLOTS_PER_CHUNK = 24;
  localparam int MAX_CHUNKS      = 8;
  localparam int TOTAL_SLOTS     = SLOTS_PER_CHUNK * MAX_CHUNKS;

  localparam int SLOT_W  = $clog2(TOTAL_SLOTS);
  localparam int LINK_W  = $clog2(TOTAL_SLOTS + 1);
  localparam int CHUNK_W = $clog2(MAX_CHUNKS + 1);

  localparam int OFF_W  = 20;
  localparam int BB_W   = 13;
  localparam int MODE_W = 2;
  localparam int STAT_W = 2;

  localparam int MIN_BLOCK  = 8;
  localparam int CMDQ_DEPTH = 2;

  localparam logic [LINK_W-1:0] LINK_END = LINK_W'(TOTAL_SLOTS);

  localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RELINK = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STAT_W-1:0] ST_INVALID   = 2'd2;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_RELINK,
    OP_NOP
  } op_e;

  // ok: free offset is aligned and inside the whole pool, slot is its index
  typedef struct packed {
    op_e               op;
    logic              ok;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

  function automatic logic [BB_W-1:0] eff_block(input logic [BB_W-1:0] bb);
    return (bb < BB_W'(MIN_BLOCK)) ? BB_W'(MIN_BLOCK) : bb;
  endfunction

  function automatic logic [LINK_W-1:0] chunk_base(input logic [CHUNK_W-1:0] n);
    return LINK_W'(LINK_W'(n) * LINK_W'(SLOTS_PER_CHUNK));
  endfunction

endpackage

@@ src/fbpa_ram.sv @@
`timescale 1ns / 1ps

module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/fbpa_front.sv @@
`timescale 1ns / 1ps

module fbpa_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [fbpa_pkg::MODE_W-1:0]      mode_i,
  input  logic [fbpa_pkg::OFF_W-1:0]       byte_offset_i,
  input  logic [fbpa_pkg::BB_W-1:0]        bb_i,
  output logic                             cmd_valid_o,
  input  logic                             cmd_ready_i,
  output fbpa_pkg::cmd_t                   cmd_o
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  localparam int CNT_W = (fbpa_pkg::SLOT_W > 1) ? $clog2(fbpa_pkg::SLOT_W) : 1;
  localparam int DIV_W = fbpa_pkg::BB_W + fbpa_pkg::SLOT_W;
  localparam int LIM_W = fbpa_pkg::BB_W + fbpa_pkg::LINK_W;
  localparam int CMP_W = (DIV_W > fbpa_pkg::OFF_W) ? DIV_W : fbpa_pkg::OFF_W;

  logic [1:0]                    state_q, state_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [fbpa_pkg::OFF_W-1:0]    rem_q, rem_d;
  logic [DIV_W-1:0]              dvs_q, dvs_d;
  logic [fbpa_pkg::SLOT_W-1:0]   quo_q, quo_d;
  fbpa_pkg::op_e                 op_q, op_d;
  logic                          ok_q, ok_d;

  logic [LIM_W-1:0]              pool_bytes;
  logic                          in_pool;
  logic                          take;
  logic [fbpa_pkg::OFF_W-1:0]    rem_step;

  assign in_ready_o  = (state_q == F_IDLE);
  assign cmd_valid_o = (state_q == F_PUSH);
  assign cmd_o       = '{op: op_q, ok: ok_q, slot: quo_q};

  // the quotient fits in the slot index only below the whole pool size
  assign pool_bytes = LIM_W'(bb_i) * LIM_W'(fbpa_pkg::TOTAL_SLOTS);
  assign in_pool    = LIM_W'(byte_offset_i) < pool_bytes;

  // restoring division, one quotient bit per cycle
  assign take     = CMP_W'(rem_q) >= CMP_W'(dvs_q);
  assign rem_step = take ? fbpa_pkg::OFF_W'(CMP_W'(rem_q) - CMP_W'(dvs_q)) : rem_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    quo_d   = quo_q;
    op_d    = op_q;
    ok_d    = ok_q;
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          ok_d    = 1'b0;
          quo_d   = '0;
          state_d = F_PUSH;
          unique case (mode_i)
            fbpa_pkg::MODE_ALLOC:  op_d = fbpa_pkg::OP_ALLOC;
            fbpa_pkg::MODE_FREE: begin
              op_d = fbpa_pkg::OP_FREE;
              if (in_pool) begin
                rem_d   = byte_offset_i;
                dvs_d   = DIV_W'(bb_i) << (fbpa_pkg::SLOT_W - 1);
                cnt_d   = CNT_W'(fbpa_pkg::SLOT_W - 1);
                state_d = F_DIV;
              end
            end
            fbpa_pkg::MODE_RELINK: op_d = fbpa_pkg::OP_RELINK;
            default:               op_d = fbpa_pkg::OP_NOP;
          endcase
        end
      end
      F_DIV: begin
        rem_d = rem_step;
        dvs_d = dvs_q >> 1;
        quo_d = fbpa_pkg::SLOT_W'({quo_q, take});
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          ok_d    = (rem_step == '0);
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (cmd_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
    op_q  <= op_d;
    ok_q  <= ok_d;
  end

endmodule

@@ src/fbpa_cmdq.sv @@
`timescale 1ns / 1ps

module fbpa_cmdq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  fbpa_pkg::cmd_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output fbpa_pkg::cmd_t pop_data_o
);

  localparam int PTR_W = (fbpa_pkg::CMDQ_DEPTH > 1) ? $clog2(fbpa_pkg::CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(fbpa_pkg::CMDQ_DEPTH + 1);

  fbpa_pkg::cmd_t   mem_q [fbpa_pkg::CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(fbpa_pkg::CMDQ_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(fbpa_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(fbpa_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ src/fbpa_back.sv @@
`timescale 1ns / 1ps

module fbpa_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  fbpa_pkg::cmd_t              cmd_i,
  input  logic [fbpa_pkg::BB_W-1:0]   bb_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [fbpa_pkg::OFF_W-1:0]  granted_offset_o,
  output logic [fbpa_pkg::STAT_W-1:0] status_o
);

  localparam logic B_IDLE = 1'b0;
  localparam logic B_READ = 1'b1;

  localparam int PROD_W = fbpa_pkg::SLOT_W + fbpa_pkg::BB_W;

  logic                            state_q, state_d;
  logic [fbpa_pkg::SLOT_W-1:0]     head_q, head_d;
  logic                            empty_q, empty_d;
  logic [fbpa_pkg::CHUNK_W-1:0]    active_q, active_d;
  // a link entry without its valid bit reads as part of the ascending chain
  logic [fbpa_pkg::TOTAL_SLOTS-1:0] vld_q, vld_d;

  logic                            out_valid_q, out_valid_d;
  logic [fbpa_pkg::OFF_W-1:0]      out_off_q, out_off_d;
  logic [fbpa_pkg::STAT_W-1:0]     out_stat_q, out_stat_d;

  logic                            ram_we;
  logic [fbpa_pkg::SLOT_W-1:0]     ram_raddr;
  logic [fbpa_pkg::LINK_W-1:0]     ram_wdata, ram_rdata;

  logic [fbpa_pkg::LINK_W-1:0]     limit;
  logic [fbpa_pkg::LINK_W-1:0]     succ;
  logic [fbpa_pkg::LINK_W-1:0]     link;
  logic [PROD_W-1:0]               grant;
  logic                            grow, out_free, pop;

  assign limit    = fbpa_pkg::chunk_base(active_q);
  assign grow     = empty_q && (active_q < fbpa_pkg::CHUNK_W'(fbpa_pkg::MAX_CHUNKS));
  assign out_free = !out_valid_q || out_ready_i;

  assign cmd_ready_o = (state_q == B_IDLE) && out_free;
  assign pop         = cmd_valid_i && cmd_ready_o;

  // new chunk's first slot, or the current head
  assign ram_raddr = grow ? fbpa_pkg::SLOT_W'(limit) : head_q;
  assign ram_we    = pop && (cmd_i.op == fbpa_pkg::OP_FREE) && cmd_i.ok &&
                     (fbpa_pkg::LINK_W'(cmd_i.slot) < limit);
  assign ram_wdata = empty_q ? fbpa_pkg::LINK_END : fbpa_pkg::LINK_W'(head_q);

  assign succ  = fbpa_pkg::LINK_W'(head_q) + 1'b1;
  assign link  = vld_q[head_q] ? ram_rdata :
                 ((succ < limit) ? succ : fbpa_pkg::LINK_END);
  assign grant = PROD_W'(head_q) * PROD_W'(bb_i);

  fbpa_ram #(
    .WIDTH (fbpa_pkg::LINK_W),
    .DEPTH (fbpa_pkg::TOTAL_SLOTS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cmd_i.slot),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    empty_d     = empty_q;
    active_d    = active_q;
    vld_d       = vld_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_off_d   = out_off_q;
    out_stat_d  = out_stat_q;
    unique case (state_q)
      B_IDLE: begin
        if (pop) begin
          out_off_d  = '0;
          out_stat_d = fbpa_pkg::ST_OK;
          unique case (cmd_i.op)
            fbpa_pkg::OP_ALLOC: begin
              if (empty_q && !grow) begin
                out_valid_d = 1'b1;
                out_stat_d  = fbpa_pkg::ST_EXHAUSTED;
              end else begin
                if (grow) begin
                  head_d   = fbpa_pkg::SLOT_W'(limit);
                  empty_d  = 1'b0;
                  active_d = active_q + 1'b1;
                  for (int i = 0; i < fbpa_pkg::TOTAL_SLOTS; i++) begin
                    if (fbpa_pkg::LINK_W'(i) >= limit) begin
                      vld_d[i] = 1'b0;
                    end
                  end
                end
                state_d = B_READ;
              end
            end
            fbpa_pkg::OP_FREE: begin
              out_valid_d = 1'b1;
              if (ram_we) begin
                vld_d[cmd_i.slot] = 1'b1;
                head_d            = cmd_i.slot;
                empty_d           = 1'b0;
              end else begin
                out_stat_d = fbpa_pkg::ST_INVALID;
              end
            end
            fbpa_pkg::OP_RELINK: begin
              out_valid_d = 1'b1;
              vld_d       = '0;
              head_d      = '0;
              empty_d     = 1'b0;
            end
            default: out_valid_d = 1'b1;
          endcase
        end
      end
      B_READ: begin
        out_valid_d = 1'b1;
        out_off_d   = fbpa_pkg::OFF_W'(grant);
        out_stat_d  = fbpa_pkg::ST_OK;
        if (link >= fbpa_pkg::LINK_END) begin
          empty_d = 1'b1;
        end else begin
          head_d = fbpa_pkg::SLOT_W'(link);
        end
        state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      head_q      <= '0;
      empty_q     <= 1'b0;
      active_q    <= fbpa_pkg::CHUNK_W'(1);
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      empty_q     <= empty_d;
      active_q    <= active_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_off_q  <= out_off_d;
    out_stat_q <= out_stat_d;
  end

  assign out_valid_o      = out_valid_q;
  assign granted_offset_o = out_off_q;
  assign status_o         = out_stat_q;

endmodule

@@ src/fixed_block_pool_allocator.sv @@
`timescale 1ns / 1ps

// Free-list allocator for a pool of equal blocks, addressed by byte offset.
// Request channel (in_valid_i/in_ready_o): mode_i 0 alloc, 1 free, 2 relink
// all active slots, 3 no-op; byte_offset_i is used by free only. Each
// request gives exactly one transaction on the result channel
// (out_valid_o/out_ready_i): granted_offset_o and status_o.
// Config channel (cfg_valid_i/cfg_ready_o) writes block_bytes; always ready,
// write it only while no request is in flight.
// The front stage takes a request and, for a free inside the pool, runs a
// division (one quotient bit per cycle) to find the slot; it takes no new
// request until it has pushed its command into the 2-entry command queue.
// That queue feeds the back stage, which owns the link memory: a granted
// alloc goes through B_IDLE and B_READ there (one link-memory read), the
// rest finish in B_IDLE.
// Reset leaves chunk 0 active and chained in ascending order; link entries
// carry valid bits, so no memory clearing pass is needed.
// A stalled receiver holds the result register; the back stage stops, the
// queue fills and in_ready_o drops.

module fixed_block_pool_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [fbpa_pkg::BB_W-1:0]   block_bytes_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [fbpa_pkg::MODE_W-1:0] mode_i,
  input  logic [fbpa_pkg::OFF_W-1:0]  byte_offset_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [fbpa_pkg::OFF_W-1:0]  granted_offset_o,
  output logic [fbpa_pkg::STAT_W-1:0] status_o
);

  logic [fbpa_pkg::BB_W-1:0] bb_q;
  logic [fbpa_pkg::BB_W-1:0] bb_eff;

  logic           fq_valid, fq_ready;
  fbpa_pkg::cmd_t fq_cmd;
  logic           qb_valid, qb_ready;
  fbpa_pkg::cmd_t qb_cmd;

  assign cfg_ready_o = 1'b1;
  assign bb_eff      = fbpa_pkg::eff_block(bb_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bb_q <= fbpa_pkg::BB_W'(fbpa_pkg::MIN_BLOCK);
    end else if (cfg_valid_i) begin
      bb_q <= block_bytes_i;
    end
  end

  fbpa_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .byte_offset_i (byte_offset_i),
    .bb_i          (bb_eff),
    .cmd_valid_o   (fq_valid),
    .cmd_ready_i   (fq_ready),
    .cmd_o         (fq_cmd)
  );

  fbpa_cmdq u_cmdq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_cmd),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_data_o   (qb_cmd)
  );

  fbpa_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (qb_valid),
    .cmd_ready_o      (qb_ready),
    .cmd_i            (qb_cmd),
    .bb_i             (bb_eff),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .granted_offset_o (granted_offset_o),
    .status_o         (status_o)
  );

endmodule

@@ src/fbpa_checker.sv @@
`timescale 1ns / 1ps

module fbpa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [fbpa_pkg::OFF_W-1:0]  granted_offset_o,
  input logic [fbpa_pkg::STAT_W-1:0] status_o
);

  // requests taken whose result transaction is still outstanding
  logic [2:0] pending_q, pending_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_comb begin
    pending_d = pending_q;
    case ({in_acc, out_acc})
      2'b10:   pending_d = pending_q + 1'b1;
      2'b01:   pending_d = pending_q - 1'b1;
      default: pending_d = pending_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(granted_offset_o) && $stable(status_o))
    else $error("result changed while stalled");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != fbpa_pkg::ST_OK) |-> granted_offset_o == '0)
    else $error("nonzero offset on a failed request");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != '0)
    else $error("result without an outstanding request");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> pending_q <= 3'd3)
    else $error("request taken with pipeline and queue full");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .granted_offset_o (granted_offset_o),
  .status_o         (status_o)
);

@@ test/fixed_block_pool_allocator_tb.sv @@
`timescale 1ns / 1ps

module fixed_block_pool_allocator_tb;

  localparam int PHASE_ITEMS = 115;
  localparam int NUM_PHASES  = 10;
  localparam int MAX_IDLE    = 12;

  typedef struct packed {
    logic [fbpa_pkg::MODE_W-1:0] mode;
    logic [fbpa_pkg::OFF_W-1:0]  offset;
  } pool_req_t;

  typedef struct packed {
    logic [fbpa_pkg::OFF_W-1:0]  granted;
    logic [fbpa_pkg::STAT_W-1:0] status;
  } alloc_reply_t;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_valid_i   = 1'b0;
  logic                          cfg_ready_o;
  logic [fbpa_pkg::BB_W-1:0]     block_bytes_i = '0;
  logic                          in_valid_i    = 1'b0;
  logic                          in_ready_o;
  logic [fbpa_pkg::MODE_W-1:0]   mode_i        = fbpa_pkg::MODE_ALLOC;
  logic [fbpa_pkg::OFF_W-1:0]    byte_offset_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i   = 1'b0;
  logic [fbpa_pkg::OFF_W-1:0]    granted_offset_o;
  logic [fbpa_pkg::STAT_W-1:0]   status_o;

  fixed_block_pool_allocator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .block_bytes_i   (block_bytes_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .byte_offset_i   (byte_offset_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .granted_offset_o(granted_offset_o),
    .status_o        (status_o)
  );

  always #1 clk_i = ~clk_i;

  // free-list mirror
  logic [fbpa_pkg::BB_W-1:0]   cfg_block_bytes;
  logic [fbpa_pkg::SLOT_W-1:0] free_head;
  logic                        list_dry;
  logic [fbpa_pkg::LINK_W-1:0] succ [fbpa_pkg::TOTAL_SLOTS];
  int unsigned                 chunks_on;

  pool_req_t    request_q [$];
  alloc_reply_t grant_forecast_q [$];

  logic idle_on = 1'b1;
  int   gap_left, stall_left;
  int   mismatches, n_req, n_grants, n_exhausted, n_invalid, n_cfg;

  function automatic void chain_slots(input int unsigned lo, input int unsigned hi);
    for (int unsigned s = lo; s < hi; s++) succ[s] = fbpa_pkg::LINK_W'(s + 1);
    succ[hi] = fbpa_pkg::LINK_END;
  endfunction

  task automatic pool_step(input logic [fbpa_pkg::MODE_W-1:0] m,
                           input logic [fbpa_pkg::OFF_W-1:0] off,
                           output alloc_reply_t r);
    int unsigned bb, base, slot, lim, ofs;
    bb  = (cfg_block_bytes < fbpa_pkg::MIN_BLOCK) ? fbpa_pkg::MIN_BLOCK
                                                  : int'(cfg_block_bytes);
    ofs = off;
    lim = chunks_on * fbpa_pkg::SLOTS_PER_CHUNK;
    r.granted = '0;
    r.status  = fbpa_pkg::ST_OK;
    case (m)
      fbpa_pkg::MODE_ALLOC: begin
        // empty list grows the pool by one chunk if any is left
        if (list_dry && chunks_on < fbpa_pkg::MAX_CHUNKS) begin
          base = chunks_on * fbpa_pkg::SLOTS_PER_CHUNK;
          chain_slots(base, base + fbpa_pkg::SLOTS_PER_CHUNK - 1);
          free_head = fbpa_pkg::SLOT_W'(base);
          list_dry  = 1'b0;
          chunks_on++;
        end
        if (list_dry) begin
          r.status = fbpa_pkg::ST_EXHAUSTED;
        end else begin
          r.granted = fbpa_pkg::OFF_W'(int'(free_head) * bb);
          if (succ[free_head] >= fbpa_pkg::LINK_END) list_dry = 1'b1;
          else free_head = fbpa_pkg::SLOT_W'(succ[free_head]);
        end
      end
      fbpa_pkg::MODE_FREE: begin
        slot = ofs / bb;
        if (ofs % bb != 0 || slot >= lim) begin
          r.status = fbpa_pkg::ST_INVALID;
        end else begin
          succ[slot] = list_dry ? fbpa_pkg::LINK_END : fbpa_pkg::LINK_W'(free_head);
          free_head  = fbpa_pkg::SLOT_W'(slot);
          list_dry   = 1'b0;
        end
      end
      fbpa_pkg::MODE_RELINK: begin
        chain_slots(0, lim - 1);
        free_head = '0;
        list_dry  = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    alloc_reply_t fc;
    pool_req_t    req;
    logic         held;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      mode_i        <= fbpa_pkg::MODE_ALLOC;
      byte_offset_i <= '0;
      gap_left = 0;
    end else begin
      held = in_valid_i && !in_ready_o;
      if (in_valid_i && in_ready_o) begin
        pool_step(mode_i, byte_offset_i, fc);
        grant_forecast_q.push_back(fc);
        n_req++;
        if (mode_i == fbpa_pkg::MODE_ALLOC && fc.status == fbpa_pkg::ST_OK) n_grants++;
        if (fc.status == fbpa_pkg::ST_EXHAUSTED) n_exhausted++;
        if (fc.status == fbpa_pkg::ST_INVALID) n_invalid++;
        gap_left = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (!held) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (request_q.size() != 0) begin
          req = request_q.pop_front();
          in_valid_i    <= 1'b1;
          mode_i        <= req.mode;
          byte_offset_i <= req.offset;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin : watch_results
    alloc_reply_t fc;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (grant_forecast_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result offset=0x%05h status=%0d",
                                  granted_offset_o, status_o));
        end else begin
          fc = grant_forecast_q.pop_front();
          if (granted_offset_o !== fc.granted)
            flag_mismatch($sformatf("granted_offset expected 0x%05h got 0x%05h",
                                    fc.granted, granted_offset_o));
          if (status_o !== fc.status)
            flag_mismatch($sformatf("status expected %0d got %0d", fc.status, status_o));
        end
        stall_left = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic queue_req(input logic [fbpa_pkg::MODE_W-1:0] m,
                           input logic [fbpa_pkg::OFF_W-1:0] off);
    pool_req_t req;
    req.mode   = m;
    req.offset = off;
    request_q.push_back(req);
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || in_valid_i || grant_forecast_q.size() != 0)
      @(negedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic write_block_bytes(input logic [fbpa_pkg::BB_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i   <= 1'b1;
    block_bytes_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_block_bytes = value;
    cfg_valid_i <= 1'b0;
    n_cfg++;
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [fbpa_pkg::BB_W-1:0]   cfg_plan [NUM_PHASES];
    int unsigned                 pick, k, slot_sel, bb_now, ofs;
    logic                        heavy;
    logic [fbpa_pkg::MODE_W-1:0] m;

    cfg_plan = '{13'd8, 13'd0, 13'd5, 13'd4096, 13'd8191, 13'd1, 13'd13, 13'd24,
                 13'd100, 13'd8};
    cfg_plan[NUM_PHASES-1] = fbpa_pkg::BB_W'($urandom_range(8, 4096));

    // state right after reset
    for (int s = 0; s < fbpa_pkg::TOTAL_SLOTS; s++) succ[s] = '0;
    chain_slots(0, fbpa_pkg::SLOTS_PER_CHUNK - 1);
    free_head       = '0;
    list_dry        = 1'b0;
    chunks_on       = 1;
    cfg_block_bytes = fbpa_pkg::BB_W'(fbpa_pkg::MIN_BLOCK);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, reset block size
    queue_req(fbpa_pkg::MODE_ALLOC, '0);
    queue_req(fbpa_pkg::MODE_ALLOC, '1);
    queue_req(fbpa_pkg::MODE_FREE, 20'd0);
    queue_req(fbpa_pkg::MODE_FREE, 20'd0);       // same block freed twice
    queue_req(fbpa_pkg::MODE_ALLOC, '0);
    queue_req(fbpa_pkg::MODE_ALLOC, '0);
    queue_req(fbpa_pkg::MODE_ALLOC, '0);
    queue_req(fbpa_pkg::MODE_FREE, 20'd3);       // misaligned
    queue_req(fbpa_pkg::MODE_FREE, 20'd192);     // first slot past the active chunk
    queue_req(fbpa_pkg::MODE_FREE, 20'hFFFFF);
    queue_req(fbpa_pkg::MODE_FREE, 20'hFFFF8);
    queue_req(fbpa_pkg::MODE_FREE, 20'd184);     // last slot of chunk 0
    queue_req(fbpa_pkg::MODE_UNUSED, 20'hFFFFF);
    queue_req(fbpa_pkg::MODE_RELINK, 20'h55555);
    queue_req(fbpa_pkg::MODE_ALLOC, 20'hAAAAA);
    queue_req(fbpa_pkg::MODE_FREE, 20'd8);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        wait_drained();
        write_block_bytes(cfg_plan[p]);
      end
      idle_on = (p % 4 != 3);
      heavy   = (p % 3 != 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        while (request_q.size() >= 4) @(negedge clk_i);
        pick = $urandom_range(0, 99);
        if (heavy)
          m = (pick < 86) ? fbpa_pkg::MODE_ALLOC :
              (pick < 98) ? fbpa_pkg::MODE_FREE : fbpa_pkg::MODE_UNUSED;
        else
          m = (pick < 45) ? fbpa_pkg::MODE_ALLOC : (pick < 90) ? fbpa_pkg::MODE_FREE :
              (pick < 95) ? fbpa_pkg::MODE_RELINK : fbpa_pkg::MODE_UNUSED;
        ofs = $urandom();
        if (m == fbpa_pkg::MODE_FREE) begin
          bb_now   = (cfg_block_bytes < fbpa_pkg::MIN_BLOCK) ? fbpa_pkg::MIN_BLOCK
                                                             : int'(cfg_block_bytes);
          slot_sel = $urandom_range(0, chunks_on * fbpa_pkg::SLOTS_PER_CHUNK - 1);
          k        = $urandom_range(0, 99);
          if (k < 60) ofs = slot_sel * bb_now;
          else if (k < 72) ofs = $urandom_range(0, fbpa_pkg::TOTAL_SLOTS + 31) * bb_now;
          else if (k < 88) ofs = slot_sel * bb_now + $urandom_range(1, bb_now - 1);
        end
        queue_req(m, fbpa_pkg::OFF_W'(ofs));
      end
    end

    wait_drained();
    if (grant_forecast_q.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", grant_forecast_q.size()));
    $display("covered %0d requests across %0d block size writes, up to %0d chunks",
             n_req, n_cfg, chunks_on);
    $display("%0d grants, %0d exhausted, %0d rejected frees, %0d mismatches",
             n_grants, n_exhausted, n_invalid, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("timeout with %0d results outstanding", grant_forecast_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
